>>> rtl/gfsw_pkg.sv
`timescale 1ns / 1ps
// package for the gray framebuffer span writer: opcodes, job struct, constants
// no dependencies
package gfsw_pkg;

	localparam int DEF_PANEL_WIDTH  = 256;
	localparam int DEF_PANEL_HEIGHT = 64;
	localparam int STORE_DEPTH      = 8192;
	localparam int ADDR_W           = 13;
	localparam int COORD_W          = 20;
	localparam logic [7:0] HIGH_KEEP = 8'hF0;
	localparam logic [7:0] LOW_KEEP  = 8'h0F;

	typedef enum logic [2:0] {
		OP_PIXEL = 3'd0,
		OP_HSPAN = 3'd1,
		OP_VSPAN = 3'd2,
		OP_FILL  = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_DRAW,
		JOB_FILL,
		JOB_READ
	} job_kind_t;

	// one classified job: clipped start, direction, count
	typedef struct packed {
		job_kind_t            kind;
		logic                 drew;
		logic                 vertical;
		logic [COORD_W-1:0]   px;
		logic [COORD_W-1:0]   py;
		logic [COORD_W-1:0]   count;
		logic [3:0]           gray;
		logic [ADDR_W-1:0]    addr;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_WRITE,
		BK_FILL,
		BK_RDATA,
		BK_DONE
	} bk_state_t;

endpackage

>>> rtl/gfsw_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the span writer
// depends on nothing
interface gfsw_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] span_length;
	logic [3:0]  gray_level;
	logic [12:0] read_address;
	modport source (output valid, operation, pos_x, pos_y, span_length, gray_level,
		read_address, input ready);
	modport sink (input valid, operation, pos_x, pos_y, span_length, gray_level,
		read_address, output ready);
endinterface

interface gfsw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       drew_any;
	modport source (output valid, read_data, drew_any, input ready);
	modport sink (input valid, read_data, drew_any, output ready);
endinterface

>>> rtl/gfsw_front.sv
`timescale 1ns / 1ps
// front end: rotation, clipping and classification of one input beat
// depends on gfsw_pkg
module gfsw_front #(
	parameter int PANEL_WIDTH  = gfsw_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = gfsw_pkg::DEF_PANEL_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        rotation,
	gfsw_in_if.sink           in_ch,
	output logic              job_valid,
	input  logic              job_ready,
	output gfsw_pkg::job_t    job
);
	import gfsw_pkg::*;

	typedef logic signed [COORD_W-1:0] sc_t;

	localparam sc_t PW  = sc_t'(PANEL_WIDTH);
	localparam sc_t PH  = sc_t'(PANEL_HEIGHT);
	localparam sc_t ONE = sc_t'(1);

	sc_t x, y, n, sx, sy, ex, ey, a, b, c0, c1, len;
	logic is_row, on_line, drew;
	job_t nxt;
	logic full_q;

	always_comb begin
		x = sc_t'(in_ch.pos_x);
		y = sc_t'(in_ch.pos_y);
		n = sc_t'(in_ch.span_length);
		sx = x; sy = y; is_row = 1'b1;
		ex = '0; ey = '0;
		case (in_ch.operation)
			OP_HSPAN: begin
				case (rotation)
					2'd0: begin sx = x; sy = y; is_row = 1'b1; end
					2'd1: begin sx = PW - y - ONE; sy = x; is_row = 1'b0; end
					2'd2: begin sx = PW - x - n; sy = PH - y - ONE; is_row = 1'b1; end
					default: begin sx = y; sy = PH - x - n; is_row = 1'b0; end
				endcase
			end
			OP_VSPAN: begin
				case (rotation)
					2'd0: begin sx = x; sy = y; is_row = 1'b0; end
					2'd1: begin sx = PW - y - n; sy = x; is_row = 1'b1; end
					2'd2: begin sx = PW - x - ONE; sy = PH - y - n; is_row = 1'b0; end
					default: begin sx = y; sy = PH - x - ONE; is_row = 1'b1; end
				endcase
			end
			default: begin
				is_row = 1'b1;
				case (rotation)
					2'd0: begin sx = x; sy = y; end
					2'd1: begin sx = PW - y - ONE; sy = x; end
					2'd2: begin sx = PW - x - ONE; sy = PH - y - ONE; end
					default: begin sx = y; sy = PH - x - ONE; end
				endcase
			end
		endcase
		// a = coord along the span, b = fixed coord
		a = is_row ? sx : sy;
		b = is_row ? sy : sx;
		on_line = is_row ? (b >= 0 && b < PH) : (b >= 0 && b < PW);
		len = (in_ch.operation == OP_PIXEL) ? ONE : n;
		c0 = a;
		c1 = len;
		if (c0 < 0) begin
			c1 = c1 + c0;
			c0 = '0;
		end
		if (is_row) begin
			if (c0 + c1 > PW) c1 = PW - c0;
		end else begin
			if (c0 + c1 > PH) c1 = PH - c0;
		end
		drew = on_line && (c1 > 0);
		ex = is_row ? c0 : b;
		ey = is_row ? b : c0;

		nxt = '0;
		nxt.gray = in_ch.gray_level;
		nxt.addr = in_ch.read_address;
		nxt.vertical = ~is_row;
		nxt.px = ex;
		nxt.py = ey;
		nxt.count = c1;
		case (in_ch.operation)
			OP_PIXEL, OP_HSPAN, OP_VSPAN: begin
				nxt.kind = drew ? JOB_DRAW : JOB_NONE;
				nxt.drew = drew;
			end
			OP_FILL: begin
				nxt.kind = JOB_FILL;
				nxt.drew = 1'b1;
			end
			OP_READ: nxt.kind = JOB_READ;
			default: nxt.kind = JOB_NONE;
		endcase
	end

	// one-entry queue toward the back end
	assign in_ch.ready = ~full_q | job_ready;
	assign job_valid = full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (in_ch.ready) begin
			full_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) job <= nxt;
	end

	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job.kind == JOB_DRAW) |-> (job.count != '0))
		else $error("draw job with zero count");
endmodule

>>> rtl/gfsw_back.sv
`timescale 1ns / 1ps
// back end: framebuffer memory, read-modify-write walker, fill and clear sweep
// depends on gfsw_pkg
module gfsw_back #(
	parameter int PANEL_WIDTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  gfsw_pkg::job_t    job,
	gfsw_out_if.source        out_ch
);
	import gfsw_pkg::*;

	localparam int ROW_BYTES = (PANEL_WIDTH + 1) / 2;
	localparam int PIX_W = COORD_W;

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rd_q;

	bk_state_t state_q, state_d;
	logic [ADDR_W:0]  sweep_q;       // clear/fill counter, one extra bit
	logic             clearing_q;
	logic [PIX_W-1:0] px_q, py_q, cnt_q;
	logic             vert_q;
	logic [3:0]       gray_q;
	logic             drew_q;
	logic [7:0]       data_q;
	logic             ovalid_q;

	logic [31:0] idx;
	logic        idx_ok;
	logic [ADDR_W-1:0] ra;
	logic        wr_en;
	logic [ADDR_W-1:0] wa;
	logic [7:0]  wd;
	logic        take;

	assign idx = py_q * 32'(ROW_BYTES) + 32'(px_q >> 1);
	assign idx_ok = idx < 32'(STORE_DEPTH);

	assign job_ready = (state_q == BK_IDLE) && !clearing_q && !ovalid_q;
	assign take = job_valid && job_ready;

	always_comb begin
		state_d = state_q;
		ra = idx[ADDR_W-1:0];
		wr_en = 1'b0;
		wa = idx[ADDR_W-1:0];
		wd = px_q[0] ? ((rd_q & HIGH_KEEP) | {4'h0, gray_q})
			: ((rd_q & LOW_KEEP) | {gray_q, 4'h0});
		if (clearing_q) begin
			wr_en = 1'b1;
			wa = sweep_q[ADDR_W-1:0];
			wd = '0;
		end
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					case (job.kind)
						JOB_DRAW: state_d = BK_READ;
						JOB_FILL: state_d = BK_FILL;
						JOB_READ: state_d = BK_RDATA;
						default: state_d = BK_DONE;
					endcase
					ra = job.addr;
				end
			end
			BK_READ: begin
				state_d = idx_ok ? BK_WRITE : BK_DONE;
				if (!idx_ok && cnt_q != 1) state_d = BK_READ;
			end
			BK_WRITE: begin
				wr_en = 1'b1;
				state_d = (cnt_q == 1) ? BK_DONE : BK_READ;
			end
			BK_FILL: begin
				wr_en = 1'b1;
				wa = sweep_q[ADDR_W-1:0];
				wd = {gray_q, gray_q};
				if (sweep_q == (ADDR_W+1)'(STORE_DEPTH - 1)) state_d = BK_DONE;
			end
			BK_RDATA: state_d = BK_DONE;
			BK_DONE: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// read address in READ state comes from idx; rd_q holds that byte in the WRITE state that follows
	always_ff @(posedge clk) begin
		if (wr_en) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			clearing_q <= 1'b1;
			sweep_q    <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing_q) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_q == (ADDR_W+1)'(STORE_DEPTH - 1)) begin
					clearing_q <= 1'b0;
					sweep_q <= '0;
				end
			end else if (state_q == BK_FILL) begin
				sweep_q <= (state_d == BK_DONE) ? '0 : sweep_q + 1'b1;
			end
			if (state_q == BK_DONE) ovalid_q <= 1'b1;
			else if (out_ch.ready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_q   <= job.px;
			py_q   <= job.py;
			cnt_q  <= job.count;
			vert_q <= job.vertical;
			gray_q <= job.gray;
			drew_q <= job.drew;
			data_q <= '0;
		end else begin
			if (state_q == BK_RDATA) data_q <= rd_q;
			if ((state_q == BK_WRITE) || (state_q == BK_READ && !idx_ok)) begin
				cnt_q <= cnt_q - 1'b1;
				if (vert_q) py_q <= py_q + 1'b1;
				else px_q <= px_q + 1'b1;
			end
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.read_data = data_q;
	assign out_ch.drew_any = drew_q;

	a_no_take_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !job_ready) else $error("job taken during clear");
	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_WRITE) |-> $past(state_q == BK_READ)) else $error("write w/o read");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DONE) |=> ovalid_q) else $error("result lost");
endmodule

>>> rtl/gray_framebuffer_span_writer.sv
`timescale 1ns / 1ps
// top level of the 4-bit gray framebuffer span writer
// depends on gfsw_pkg, gfsw_if, gfsw_front, gfsw_back
//
// channel   dir  handshake    payload
// in_ch     in   valid/ready  operation, pos_x, pos_y, span_length, gray_level, read_address
// out_ch    out  valid/ready  read_data, drew_any
// cfg       in   cfg_we       cfg_data = rotation
//
// pixel and span: each covered pixel is a read-modify-write of its byte, a READ state then
// a WRITE state; fill: one byte per cycle over all 8192 bytes; read: one stored byte
// after reset a clearing pass writes black; meanwhile the front takes at most one beat
// the front holds one classified job, so one new beat is accepted while the back works
// a finished result sits in the output register until taken
module gray_framebuffer_span_writer #(
	parameter int PANEL_WIDTH  = gfsw_pkg::DEF_PANEL_WIDTH,
	parameter int PANEL_HEIGHT = gfsw_pkg::DEF_PANEL_HEIGHT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_data,
	gfsw_in_if.sink    in_ch,
	gfsw_out_if.source out_ch
);
	import gfsw_pkg::*;

	logic [1:0] rotation_q;
	logic       job_valid, job_ready;
	job_t       job;

	// rotation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= '0;
		end else if (cfg_we) begin
			rotation_q <= cfg_data;
		end
	end

	// front: rotate, clip, classify
	gfsw_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n), .rotation(rotation_q), .in_ch(in_ch),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	// back: memory walk, fill, read
	gfsw_back #(.PANEL_WIDTH(PANEL_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.job(job), .out_ch(out_ch)
	);
endmodule
